/* rtl/core/pse_pkg.sv */
// Package for the printable string extractor: payload structs, run state types,
// character constants and record codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

    localparam int MAX_MIN_LENGTH = 16;
    localparam int CFG_W          = 5;
    localparam int LEN_W          = $clog2(MAX_MIN_LENGTH + 1);
    localparam int IDX_W          = $clog2(MAX_MIN_LENGTH);

    localparam logic [CFG_W-1:0] MIN_LEN_RESET = 5'd4;

    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [3:0] B64_MIN  = 4'd8;
    localparam logic [1:0] PAD_MAX  = 2'd2;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       record_kind;
        logic       first_char;
        logic       looks_base64;
        logic       last_of_burst;
    } out_t;

    // Base64 pattern tracking state of the open run.
    typedef struct packed {
        logic [3:0] b64_char_count;
        logic [1:0] pad_count;
        logic       pattern_failed;
    } pat_t;

endpackage

`default_nettype wire

/* rtl/core/pse_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/pse_pattern.sv */
// Base64 pattern tracker: next pattern state for one printable byte.
// Depends on pse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pse_pattern (
    input  wire logic [7:0]  char_in,
    input  wire pse_pkg::pat_t pat_cur,
    output pse_pkg::pat_t      pat_next
);

    import pse_pkg::*;

    logic is_alpha;

    assign is_alpha = (char_in >= "A" && char_in <= "Z") ||
                      (char_in >= "a" && char_in <= "z") ||
                      (char_in >= "0" && char_in <= "9") ||
                      char_in == "+" || char_in == "/";

    always_comb begin
        pat_next = pat_cur;
        if (!pat_cur.pattern_failed) begin
            if (is_alpha) begin
                if (pat_cur.pad_count != 2'd0) begin
                    pat_next.pattern_failed = 1'b1;
                end else if (pat_cur.b64_char_count < B64_MIN) begin
                    pat_next.b64_char_count = pat_cur.b64_char_count + 4'd1;
                end
            end else if (char_in == CH_PAD) begin
                if (pat_cur.b64_char_count < B64_MIN || pat_cur.pad_count >= PAD_MAX) begin
                    pat_next.pattern_failed = 1'b1;
                end else begin
                    pat_next.pad_count = pat_cur.pad_count + 2'd1;
                end
            end else begin
                pat_next.pattern_failed = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/printable_string_extractor.sv */
// A passed-through byte or an end record enters the output register at its input transfer.
// Throughput: one byte per cycle while a run is held or passes through, unless output stalls.
// A byte that brings a run to its threshold N releases the N-1 held bytes from the
// head memory, each read then sent, before sending itself; input waits meanwhile.
// Reset is synchronous, active low; the held-byte memory is not cleared.
// Depends on pse_pkg, pse_ram and pse_pattern.
`timescale 1ns / 1ps
`default_nettype none

module printable_string_extractor (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [pse_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire pse_pkg::in_t                s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output pse_pkg::out_t                    m_data
);

    import pse_pkg::*;

    // The sequencer sits idle taking bytes, or drains the held head of a run:
    // it reads each held entry, sends it, and finally sends the byte that qualified.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND,
        ST_FINAL
    } state_t;

    state_t            state_reg,     state_next;
    logic [CFG_W-1:0]  min_len_reg,   min_len_next;
    logic [LEN_W-1:0]  run_len_reg,   run_len_next;
    logic [LEN_W-1:0]  thr_reg,       thr_next;
    pat_t              pat_reg,       pat_next;
    logic [IDX_W-1:0]  drain_idx_reg, drain_idx_next;
    logic [7:0]        cur_byte_reg,  cur_byte_next;
    out_t              out_reg,       out_next;
    logic              out_vld_reg,   out_vld_next;

    pat_t              pat_upd;
    logic              slot_free;
    logic              accept;
    logic              printable;
    logic [LEN_W-1:0]  eff_min;
    logic [LEN_W-1:0]  thr_use;
    logic              ram_we;
    logic              ram_re;
    logic [7:0]        ram_rdata;

    pse_pattern u_pattern (
        .char_in  (s_data.data_byte),
        .pat_cur  (pat_reg),
        .pat_next (pat_upd)
    );

    // Holds the first threshold-1 bytes of the open run.
    pse_ram #(
        .WIDTH (8),
        .DEPTH (MAX_MIN_LENGTH)
    ) u_head_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (run_len_reg[IDX_W-1:0]),
        .wdata (s_data.data_byte),
        .re    (ram_re),
        .raddr (drain_idx_reg),
        .rdata (ram_rdata)
    );

    // The output register may be loaded when it is empty or being emptied.
    assign slot_free = !out_vld_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_valid && s_ready;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;
    assign ram_re    = (state_reg == ST_FETCH);

    assign printable = !s_data.end_of_input &&
                       s_data.data_byte >= PRINT_LO && s_data.data_byte <= PRINT_HI;

    // A threshold of zero acts as one, and anything above the head depth is clamped.
    always_comb begin
        if (min_len_reg == '0) begin
            eff_min = LEN_W'(1);
        end else if (int'(min_len_reg) > MAX_MIN_LENGTH) begin
            eff_min = LEN_W'(MAX_MIN_LENGTH);
        end else begin
            eff_min = LEN_W'(min_len_reg);
        end
    end

    // The threshold is latched by the first byte of each run.
    assign thr_use = (run_len_reg == '0) ? eff_min : thr_reg;

    always_comb begin
        state_next     = state_reg;
        min_len_next   = cfg_we ? cfg_wdata : min_len_reg;
        run_len_next   = run_len_reg;
        thr_next       = thr_reg;
        pat_next       = pat_reg;
        drain_idx_next = drain_idx_reg;
        cur_byte_next  = cur_byte_reg;
        out_next       = out_reg;
        out_vld_next   = out_vld_reg && !m_ready;
        ram_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (printable) begin
                        thr_next = thr_use;
                        pat_next = pat_upd;
                        if (run_len_reg >= thr_use) begin
                            // Past the threshold: the byte passes straight through.
                            out_next     = '{s_data.data_byte, KIND_CHAR, 1'b0, 1'b0, 1'b1};
                            out_vld_next = 1'b1;
                        end else begin
                            run_len_next = run_len_reg + LEN_W'(1);
                            if (run_len_next == thr_use) begin
                                if (thr_use == LEN_W'(1)) begin
                                    out_next     = '{s_data.data_byte, KIND_CHAR,
                                                     1'b1, 1'b0, 1'b1};
                                    out_vld_next = 1'b1;
                                end else begin
                                    cur_byte_next  = s_data.data_byte;
                                    drain_idx_next = '0;
                                    state_next     = ST_FETCH;
                                end
                            end else begin
                                ram_we = 1'b1;
                            end
                        end
                    end else begin
                        // A non-printable byte or end of input closes the run.
                        if (run_len_reg != '0 && run_len_reg >= thr_reg) begin
                            out_next     = '{8'd0, KIND_END, 1'b0,
                                             !pat_reg.pattern_failed &&
                                             pat_reg.b64_char_count >= B64_MIN,
                                             1'b1};
                            out_vld_next = 1'b1;
                        end
                        run_len_next = '0;
                        pat_next     = '0;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (slot_free) begin
                    out_next       = '{ram_rdata, KIND_CHAR, drain_idx_reg == '0, 1'b0, 1'b0};
                    out_vld_next   = 1'b1;
                    drain_idx_next = drain_idx_reg + IDX_W'(1);
                    if (LEN_W'(drain_idx_reg) == thr_reg - LEN_W'(2)) begin
                        state_next = ST_FINAL;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FINAL: begin
                if (slot_free) begin
                    out_next     = '{cur_byte_reg, KIND_CHAR, 1'b0, 1'b0, 1'b1};
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            min_len_reg <= MIN_LEN_RESET;
            run_len_reg <= '0;
            thr_reg     <= LEN_W'(MIN_LEN_RESET);
            pat_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            min_len_reg <= min_len_next;
            run_len_reg <= run_len_next;
            thr_reg     <= thr_next;
            pat_reg     <= pat_next;
            out_vld_reg <= out_vld_next;
        end
        drain_idx_reg <= drain_idx_next;
        cur_byte_reg  <= cur_byte_next;
        out_reg       <= out_next;
    end

endmodule

`default_nettype wire
